// File: hdl/frc_pkg.sv
package frc_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int CNT_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = 16;
  localparam int CMP_W     = LEN_W + 1;

  localparam logic [7:0] SYNC_VALUE     = 8'hAA;
  localparam logic [7:0] SET_PARAM_TYPE = 8'h10;
  localparam logic [7:0] ID_LIMIT       = 8'd5;

  typedef enum logic [2:0] {
    ST_PARAM_SET  = 3'd0,
    ST_BAD_CHECK  = 3'd1,
    ST_IGNORED    = 3'd2,
    ST_UNKNOWN_ID = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  param_index;
    logic [31:0] param_word;
  } result_t;

endpackage

// File: hdl/framed_command_receiver.sv
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_rx_byte
// out      output     out_valid, out_stall, out_status, out_param_index, out_param_word
//
// One received byte per cycle while in_stall is low; a frame result is registered
// in the cycle after its check byte (or length low byte, for too_long) is taken.
// Synchronous active-low reset returns the parser to idle with no result held.
// in_stall rises only while a result waits in the output register and
// out_stall is high.
module framed_command_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_param_index,
  output logic [31:0] out_param_word
);

  logic             take;
  logic             res_valid;
  logic             full;
  frc_pkg::result_t res;
  frc_pkg::result_t out_res;

  assign in_stall = full & out_stall;
  assign take     = in_valid & ~in_stall;

  frc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  frc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .full      (full),
    .out_res   (out_res)
  );

  assign out_valid       = full;
  assign out_status      = out_res.status;
  assign out_param_index = out_res.param_index;
  assign out_param_word  = out_res.param_word;

`ifndef SYNTHESIS
  a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != frc_pkg::ST_PARAM_SET)
      |-> (out_param_index == 3'd0) && (out_param_word == 32'd0))
    else $error("non param_set transaction carries a parameter");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == frc_pkg::ST_PARAM_SET) |-> out_param_index <= 3'd5)
    else $error("param_index out of range");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid |=> out_valid && (out_status == $past(res.status)))
    else $error("result lost on its way to the output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");
`endif

endmodule

// File: hdl/frc_parser.sv
module frc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output frc_pkg::result_t   res
);

  logic [frc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [frc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic [7:0]                index_r, index_nxt;
  logic [31:0]               word_r, word_nxt;

  logic [frc_pkg::CNT_W-1:0] pos;
  logic [frc_pkg::LEN_W-1:0] full_len;
  logic                      too_long;
  logic                      frame_end;
  logic                      go_idle;

  assign pos       = count_r - frc_pkg::CNT_W'(4);
  assign full_len  = {len_r[frc_pkg::LEN_W-1:8], rx_byte};
  assign too_long  = (frc_pkg::CMP_W'(full_len) + frc_pkg::CMP_W'(5))
                     > frc_pkg::CMP_W'(frc_pkg::BUF_DEPTH);
  assign frame_end = (frc_pkg::CMP_W'(count_r) == frc_pkg::CMP_W'(len_r) + frc_pkg::CMP_W'(4));

  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    xor_nxt   = xor_r;
    index_nxt = index_r;
    word_nxt  = word_r;
    res_valid = 1'b0;
    go_idle   = 1'b0;
    res       = '{status: frc_pkg::ST_PARAM_SET, param_index: 3'd0, param_word: 32'd0};
    if (take) begin
      if (count_r == '0) begin
        if (rx_byte == frc_pkg::SYNC_VALUE) begin
          xor_nxt   = rx_byte;
          count_nxt = frc_pkg::CNT_W'(1);
        end
      end else begin
        xor_nxt   = xor_r ^ rx_byte;
        count_nxt = count_r + frc_pkg::CNT_W'(1);
        if (count_r == frc_pkg::CNT_W'(1)) begin
          type_nxt = rx_byte;
        end else if (count_r == frc_pkg::CNT_W'(2)) begin
          len_nxt = {rx_byte, 8'd0};
        end else if (count_r == frc_pkg::CNT_W'(3)) begin
          len_nxt = full_len;
          if (too_long) begin
            res_valid  = 1'b1;
            res.status = frc_pkg::ST_TOO_LONG;
            go_idle    = 1'b1;
          end
        end else if (frame_end) begin
          res_valid = 1'b1;
          go_idle   = 1'b1;
          if ((xor_r ^ rx_byte) != 8'd0) begin
            res.status = frc_pkg::ST_BAD_CHECK;
          end else if (type_r != frc_pkg::SET_PARAM_TYPE) begin
            res.status = frc_pkg::ST_IGNORED;
          end else if (len_r == '0) begin
            res.status = frc_pkg::ST_EMPTY;
          end else if (index_r > frc_pkg::ID_LIMIT) begin
            res.status = frc_pkg::ST_UNKNOWN_ID;
          end else begin
            res.status      = frc_pkg::ST_PARAM_SET;
            res.param_index = index_r[2:0];
            res.param_word  = (len_r >= frc_pkg::LEN_W'(5)) ? word_r : 32'd0;
          end
        end else begin
          case (pos)
            frc_pkg::CNT_W'(0): index_nxt = rx_byte;
            frc_pkg::CNT_W'(1): word_nxt[7:0]   = rx_byte;
            frc_pkg::CNT_W'(2): word_nxt[15:8]  = rx_byte;
            frc_pkg::CNT_W'(3): word_nxt[23:16] = rx_byte;
            frc_pkg::CNT_W'(4): word_nxt[31:24] = rx_byte;
            default: ;
          endcase
        end
      end
      if (go_idle) begin
        count_nxt = '0;
        len_nxt   = '0;
        type_nxt  = 8'd0;
        xor_nxt   = 8'd0;
        index_nxt = 8'd0;
        word_nxt  = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      type_r  <= 8'd0;
      xor_r   <= 8'd0;
      index_r <= 8'd0;
      word_r  <= 32'd0;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      xor_r   <= xor_nxt;
      index_r <= index_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

// File: hdl/frc_out_stage.sv
module frc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  frc_pkg::result_t res,
  input  logic             out_stall,
  output logic             full,
  output frc_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  frc_pkg::result_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign full    = valid_r;
  assign out_res = data_r;

endmodule

// File: tb/framed_command_receiver_tb.sv
`timescale 1ns / 100ps

module framed_command_receiver_tb;

  localparam int RANDOM_BYTES = 1500;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DIR_ROWS     = 32;

  typedef struct packed {
    logic [7:0]       data;
    logic             typed;
    frc_pkg::result_t want;
  } rx_item_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_BUSY} rx_mode_t;

  localparam frc_pkg::result_t NO_RESULT = '{frc_pkg::ST_PARAM_SET, 3'd0, 32'd0};

  localparam rx_item_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{frc_pkg::ST_TOO_LONG, 3'd0, 32'd0}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{frc_pkg::ST_BAD_CHECK, 3'd0, 32'd0}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h55, 1'b1, '{frc_pkg::ST_IGNORED, 3'd0, 32'd0}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hBA, 1'b1, '{frc_pkg::ST_EMPTY, 3'd0, 32'd0}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h44, 1'b1, '{frc_pkg::ST_UNKNOWN_ID, 3'd0, 32'd0}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT},
    '{8'hBE, 1'b1, '{frc_pkg::ST_PARAM_SET, 3'd5, 32'd0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [2:0]  out_param_index;
  logic [31:0] out_param_word;

  rx_item_t         byte_q[$];
  rx_item_t         offered;
  frc_pkg::result_t pending_results[$];
  int               errors;
  int               bytes_taken;
  int               results_taken;
  int               status_seen [8];
  bit               feed_done;

  int unsigned frame_pos;
  logic [15:0] frame_len;
  logic [7:0]  frame_kind;
  logic [7:0]  frame_xor;
  logic [7:0]  param_id;
  logic [31:0] param_acc;

  framed_command_receiver i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_param_index (out_param_index),
    .out_param_word  (out_param_word)
  );

  function automatic void clear_frame();
    frame_pos  = 0;
    frame_len  = '0;
    frame_kind = '0;
    frame_xor  = '0;
    param_id   = '0;
    param_acc  = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output frc_pkg::result_t res);
    res = NO_RESULT;
    if (frame_pos == 0) begin
      if (b == frc_pkg::SYNC_VALUE) begin
        frame_xor = b;
        frame_pos = 1;
      end
      return 1'b0;
    end
    if (frame_pos == 1) begin
      frame_kind = b;
    end else if (frame_pos == 2) begin
      frame_len[15:8] = b;
    end else if (frame_pos == 3) begin
      frame_len[7:0] = b;
      if (5 + frame_len > frc_pkg::BUF_DEPTH) begin
        res.status = frc_pkg::ST_TOO_LONG;
        clear_frame();
        return 1'b1;
      end
    end else if (frame_pos == 4 + frame_len) begin
      if (frame_xor != b) begin
        res.status = frc_pkg::ST_BAD_CHECK;
      end else if (frame_kind != frc_pkg::SET_PARAM_TYPE) begin
        res.status = frc_pkg::ST_IGNORED;
      end else if (frame_len == 0) begin
        res.status = frc_pkg::ST_EMPTY;
      end else if (param_id > frc_pkg::ID_LIMIT) begin
        res.status = frc_pkg::ST_UNKNOWN_ID;
      end else begin
        res.status      = frc_pkg::ST_PARAM_SET;
        res.param_index = param_id[2:0];
        res.param_word  = (frame_len >= 5) ? param_acc : '0;
      end
      clear_frame();
      return 1'b1;
    end else if (frame_pos == 4) begin
      param_id = b;
    end else if (frame_pos <= 8) begin
      param_acc[8*(frame_pos-5) +: 8] = b;
    end
    frame_xor = frame_xor ^ b;
    frame_pos++;
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{b, 1'b0, NO_RESULT});
  endtask

  task automatic load_random();
    int          roll;
    int          n;
    int          i;
    int unsigned budget;
    logic [7:0]  ftype;
    logic [7:0]  chk;
    logic [7:0]  b;
    logic [15:0] flen;
    budget = 0;
    while (budget < RANDOM_BYTES) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        n = $urandom_range(1, 3);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end else if (roll < 13) begin
        n = $urandom_range(1, 6);
        push_byte(frc_pkg::SYNC_VALUE);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        budget += n + 1;
      end else begin
        ftype = ($urandom_range(0, 9) < 8) ? frc_pkg::SET_PARAM_TYPE
                                           : 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 19);
        if (roll == 0) flen = 16'($urandom_range(frc_pkg::BUF_DEPTH - 4, 16'hFFFF));
        else if (roll == 1) begin
          flen = 16'($urandom_range(frc_pkg::BUF_DEPTH - 5, frc_pkg::BUF_DEPTH - 4));
        end
        else if (roll < 5) flen = 16'($urandom_range(0, 4));
        else if (roll < 15) flen = 16'd5;
        else flen = 16'($urandom_range(6, frc_pkg::BUF_DEPTH - 5));
        chk = frc_pkg::SYNC_VALUE ^ ftype ^ flen[15:8] ^ flen[7:0];
        push_byte(frc_pkg::SYNC_VALUE);
        push_byte(ftype);
        push_byte(flen[15:8]);
        push_byte(flen[7:0]);
        budget += 4;
        if (5 + flen <= frc_pkg::BUF_DEPTH) begin
          for (i = 0; i < flen; i++) begin
            if (i == 0 && $urandom_range(0, 4) != 0) begin
              b = 8'($urandom_range(0, frc_pkg::ID_LIMIT));
            end
            else b = 8'($urandom_range(0, 255));
            chk = chk ^ b;
            push_byte(b);
          end
          push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : chk);
          budget += flen + 1;
        end
      end
    end
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : reset_gen
    rst_n = 1'b0;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  initial begin : sender
    int burst_left;
    int gap;
    int r;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    offered    = '0;
    for (r = 0; r < DIR_ROWS; r++) byte_q.push_back(DIRECTED[r]);
    load_random();
    wait (rst_n);
    @(negedge clk);
    burst_left = 0;
    while (byte_q.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end
      offered    = byte_q.pop_front();
      in_rx_byte = offered.data;
      in_valid   = 1'b1;
      do @(posedge clk); while (in_stall);
      burst_left--;
      @(negedge clk);
    end
    in_valid  = 1'b0;
    feed_done = 1'b1;
  end

  initial begin : receiver
    int       hold_left;
    int       mode_left;
    int       phase;
    bit       hold_done;
    rx_mode_t mode;
    out_stall = 1'b0;
    hold_left = 0;
    mode_left = 0;
    phase     = 0;
    hold_done = 1'b0;
    mode      = RX_FREE;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_FREE:    out_stall = 1'b0;
          RX_COIN:    out_stall = ($urandom_range(0, 1) == 1);
          RX_PATTERN: out_stall = (phase % 5) < 2;
          default:    out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    frc_pkg::result_t res;
    frc_pkg::result_t want;
    bit               made;
    if (rst_n && in_valid && !in_stall) begin
      bytes_taken++;
      made = parse_byte(offered.data, res);
      if (offered.typed) pending_results.push_back(offered.want);
      else if (made) pending_results.push_back(res);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      status_seen[out_status]++;
      if (pending_results.size() == 0) begin
        errors++;
        $error("unexpected result transaction: status %0d", out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, out_status);
        end
        if (out_param_index !== want.param_index) begin
          errors++;
          $error("param_index: expected %0d, got %0d", want.param_index, out_param_index);
        end
        if (out_param_word !== want.param_word) begin
          errors++;
          $error("param_word: expected %h, got %h", want.param_word, out_param_word);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : end_of_run
    wait (feed_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Fed %0d bytes, checked %0d frame statuses: %0d set, %0d bad check, %0d ignored,",
             bytes_taken, results_taken, status_seen[frc_pkg::ST_PARAM_SET],
             status_seen[frc_pkg::ST_BAD_CHECK], status_seen[frc_pkg::ST_IGNORED]);
    $display("  %0d unknown id, %0d empty, %0d oversize; long output hold-off included",
             status_seen[frc_pkg::ST_UNKNOWN_ID], status_seen[frc_pkg::ST_EMPTY],
             status_seen[frc_pkg::ST_TOO_LONG]);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
hdl/frc_pkg.sv
hdl/frc_parser.sv
hdl/frc_out_stage.sv
hdl/framed_command_receiver.sv
tb/framed_command_receiver_tb.sv
